// File: sv/lfwg_pkg.sv
package lfwg_pkg;

	// frame phases
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_BURST = 3'd1;
	localparam logic [2:0] PH_GAP   = 3'd2;
	localparam logic [2:0] PH_PRE   = 3'd3;
	localparam logic [2:0] PH_PAT   = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_BIT_DURATION   = 3'd0;
	localparam logic [2:0] REG_BURST_DURATION = 3'd1;
	localparam logic [2:0] REG_PREAMBLE_COUNT = 3'd2;
	localparam logic [2:0] REG_PATTERN_IS_32  = 3'd3;
	localparam logic [2:0] REG_DOUBLE_PATTERN = 3'd4;
	localparam logic [2:0] REG_WAKE_PATTERN   = 3'd5;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	// register reset values
	localparam logic [14:0] RST_BIT_DURATION   = 15'd54;
	localparam logic [15:0] RST_BURST_DURATION = 16'd350;
	localparam logic [7:0]  RST_PREAMBLE_COUNT = 8'd5;
	localparam logic        RST_PATTERN_IS_32  = 1'b0;
	localparam logic        RST_DOUBLE_PATTERN = 1'b0;
	localparam logic [31:0] RST_WAKE_PATTERN   = 32'h9669_5555;

	// first bit position of a pass
	localparam logic [4:0] POS_FIRST_32 = 5'd31;
	localparam logic [4:0] POS_FIRST_16 = 5'd15;
	// 16-bit mode sends the upper half of the pattern
	localparam logic [4:0] UPPER_HALF_OFS = 5'd16;

	typedef struct packed {
		logic [14:0] bit_duration;
		logic [15:0] burst_duration;
		logic [7:0]  preamble_count;
		logic        pattern_is_32;
		logic        double_pattern;
		logic [31:0] wake_pattern;
	} cfg_t;

	typedef struct packed {
		logic carrier_on;
		logic busy_res;
		logic frame_end;
	} res_t;

endpackage

// File: sv/lfwg_cfg.sv
module lfwg_cfg
	import lfwg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_duration   <= RST_BIT_DURATION;
			cfg_q.burst_duration <= RST_BURST_DURATION;
			cfg_q.preamble_count <= RST_PREAMBLE_COUNT;
			cfg_q.pattern_is_32  <= RST_PATTERN_IS_32;
			cfg_q.double_pattern <= RST_DOUBLE_PATTERN;
			cfg_q.wake_pattern   <= RST_WAKE_PATTERN;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BIT_DURATION:   cfg_q.bit_duration   <= cfg_wdata[14:0];
				REG_BURST_DURATION: cfg_q.burst_duration <= cfg_wdata[15:0];
				REG_PREAMBLE_COUNT: cfg_q.preamble_count <= cfg_wdata[7:0];
				REG_PATTERN_IS_32:  cfg_q.pattern_is_32  <= cfg_wdata[0];
				REG_DOUBLE_PATTERN: cfg_q.double_pattern <= cfg_wdata[0];
				REG_WAKE_PATTERN:   cfg_q.wake_pattern   <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/lfwg_seq.sv
module lfwg_seq
	import lfwg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic start_req,
	input  cfg_t cfg,
	output res_t res
);

	logic [2:0]  phase_q;
	logic [15:0] tick_q;
	logic [7:0]  symbols_q;
	logic        half_q;
	logic [4:0]  pos_q;
	logic        second_q;

	logic [2:0]  phase_a, phase_n;
	logic [15:0] tick_a, tick_n;
	logic [7:0]  symbols_n;
	logic        half_n;
	logic [4:0]  pos_n;
	logic        second_a, second_n;
	logic [16:0] tick_inc;
	logic [15:0] len;
	logic [4:0]  pos_first;
	logic [4:0]  pat_idx;
	logic        bit_zero;

	always_comb begin
		bit_zero  = (cfg.bit_duration == '0);
		pos_first = cfg.pattern_is_32 ? POS_FIRST_32 : POS_FIRST_16;
		pat_idx   = cfg.pattern_is_32 ? pos_q : ({1'b0, pos_q[3:0]} + UPPER_HALF_OFS);

		// start: zero-length leading phases are skipped right away
		phase_a  = phase_q;
		tick_a   = tick_q;
		second_a = second_q;
		if (phase_q == PH_IDLE && start_req) begin
			tick_a   = '0;
			second_a = 1'b0;
			if (cfg.burst_duration != '0)
				phase_a = PH_BURST;
			else if (!bit_zero)
				phase_a = PH_GAP;
			else
				phase_a = PH_IDLE;
		end

		phase_n   = phase_a;
		tick_n    = tick_a;
		symbols_n = symbols_q;
		half_n    = half_q;
		pos_n     = pos_q;
		second_n  = second_a;
		res       = '0;

		len      = (phase_a == PH_BURST) ? cfg.burst_duration : {1'b0, cfg.bit_duration};
		tick_inc = {1'b0, tick_a} + 17'd1;

		if (phase_a != PH_IDLE) begin
			res.busy_res = 1'b1;
			case (phase_a)
				PH_BURST: res.carrier_on = 1'b1;
				PH_PRE:   res.carrier_on = ~half_q;
				PH_PAT:   res.carrier_on = cfg.wake_pattern[pat_idx];
				default:  res.carrier_on = 1'b0;
			endcase

			if (tick_inc >= {1'b0, len}) begin
				tick_n = '0;
				case (phase_a)
					PH_BURST: begin
						// with zero bit time nothing follows the burst
						phase_n = bit_zero ? PH_IDLE : PH_GAP;
					end
					PH_GAP: begin
						symbols_n = cfg.preamble_count;
						half_n    = 1'b0;
						if (cfg.preamble_count == '0) begin
							phase_n  = PH_PAT;
							second_n = 1'b0;
							pos_n    = pos_first;
						end else begin
							phase_n = PH_PRE;
						end
					end
					PH_PRE: begin
						if (!half_q) begin
							half_n = 1'b1;
						end else begin
							half_n    = 1'b0;
							symbols_n = symbols_q - 8'd1;
							if (symbols_q == 8'd1) begin
								phase_n  = PH_PAT;
								second_n = 1'b0;
								pos_n    = pos_first;
							end
						end
					end
					PH_PAT: begin
						if (pos_q != '0) begin
							pos_n = pos_q - 5'd1;
						end else if (cfg.double_pattern && !second_a) begin
							second_n = 1'b1;
							pos_n    = pos_first;
						end else begin
							phase_n = PH_IDLE;
						end
					end
					default: phase_n = PH_IDLE;
				endcase
				// zero bit time makes every later phase empty
				if (bit_zero)
					phase_n = PH_IDLE;
				res.frame_end = (phase_n == PH_IDLE);
			end else begin
				tick_n = tick_inc[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= '0;
			symbols_q <= '0;
			half_q    <= 1'b0;
			pos_q     <= '0;
			second_q  <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_n;
			tick_q    <= tick_n;
			symbols_q <= symbols_n;
			half_q    <= half_n;
			pos_q     <= pos_n;
			second_q  <= second_n;
		end
	end

endmodule

// File: sv/lf_wakeup_frame_generator.sv
// a tick's transaction on the input is registered in the input register, then
// its result in the result register
// throughput: one tick per clock unless m_tready stalls the output; the frame sequencer updates once per tick
// reset: arst_n clears both stages and the sequencer to idle, and loads the
// configuration registers with their default values
module lf_wakeup_frame_generator
	import lfwg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // [0] start_req
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,  // [0] carrier_on, [1] busy_res
	output logic                  m_tlast   // frame_end
);

	cfg_t cfg;
	res_t res;

	logic valid_s1;
	logic start_s1;
	logic advance;
	logic valid_s2;
	res_t res_s2;

	lfwg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// input stage moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			start_s1 <= s_tdata[0];
		end
	end

	lfwg_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.start_req (start_s1),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.busy_res, res_s2.carrier_on};
	assign m_tlast  = res_s2.frame_end;

	a_end_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[1])
		else $error("frame end outside a frame");

	a_carrier_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[1])
		else $error("carrier on while idle");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(start_s1))
		else $error("stalled input item lost");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(res_s2))
		else $error("pending result overwritten");

endmodule
